// ===== design/tc_pkg.sv =====
// ============================================================================
// tc_pkg
// Shared constants, codes and types of the triangle rectangle clipper.
// ============================================================================
package tc_pkg;

    // Default coordinate width
    localparam int COORD_BITS_DEF = 16;

    // Vertex buffer depth; four passes over a triangle stay below it
    localparam int BUF_DEPTH = 64;

    // Output polygon limits
    localparam int MIN_OUT = 3;
    localparam int MAX_OUT = 7;

    // Reset value of the right and bottom window edges
    localparam int EDGE_FAR_RST = 1023;

    // Configuration register indexes
    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] REG_LEFT   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_TOP    = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_RIGHT  = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_BOTTOM = 2'd3;

    // Triangle classes decided by the front end
    localparam logic [1:0] CLS_REJECT = 2'd0;
    localparam logic [1:0] CLS_ACCEPT = 2'd1;
    localparam logic [1:0] CLS_CLIP   = 2'd2;

    // Clip pass order
    localparam logic [1:0] PASS_LEFT   = 2'd0;
    localparam logic [1:0] PASS_RIGHT  = 2'd1;
    localparam logic [1:0] PASS_TOP    = 2'd2;
    localparam logic [1:0] PASS_BOTTOM = 2'd3;

    // Queue head status seen by the back end
    typedef struct packed {
        logic       valid;
        logic [1:0] cls;
    } tq_head_t;

endpackage

// ===== design/tc_ram.sv =====
// ============================================================================
// tc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ============================================================================
module tc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== design/tc_div.sv =====
// ============================================================================
// tc_div
// Restoring unsigned divider, one quotient bit per cycle. The caller
// guarantees that the quotient fits in W bits.
// ============================================================================
module tc_div #(
    parameter int W = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [2*W-1:0] dividend,
    input  logic [W-1:0]   divisor,
    output logic           done,
    output logic [W-1:0]   quotient
);

    localparam int CNTW = $clog2(W + 1);

    logic            run_reg, run_next;
    logic            done_reg, done_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]    rem_reg, rem_next;
    logic [W-1:0]    low_reg, low_next;
    logic [W-1:0]    dvs_reg, dvs_next;
    logic [W-1:0]    quo_reg, quo_next;
    logic [W:0]      trial;
    logic [W:0]      diff;
    logic            ge;

    // One restoring step
    assign trial = {rem_reg, low_reg[W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign ge    = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        low_next  = low_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = CNTW'(W);
            rem_next = dividend[2*W-1:W];
            low_next = dividend[W-1:0];
            dvs_next = divisor;
        end
        else if (run_reg)
        begin
            rem_next = ge ? diff[W-1:0] : trial[W-1:0];
            low_next = {low_reg[W-2:0], 1'b0};
            quo_next = {quo_reg[W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNTW'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        low_reg <= low_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

    // done follows a step of an active division
    a_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(run_reg))
        else $error("divider done without a running division");

endmodule

// ===== design/tc_front.sv =====
// ============================================================================
// tc_front
// Takes triangles, classifies them against the window by outcodes and
// queues them for the clipping back end.
// ============================================================================
module tc_front import tc_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic signed [COORD_BITS-1:0]   v0_x,
    input  logic signed [COORD_BITS-1:0]   v0_y,
    input  logic signed [COORD_BITS-1:0]   v1_x,
    input  logic signed [COORD_BITS-1:0]   v1_y,
    input  logic signed [COORD_BITS-1:0]   v2_x,
    input  logic signed [COORD_BITS-1:0]   v2_y,
    input  logic signed [COORD_BITS-1:0]   clip_left,
    input  logic signed [COORD_BITS-1:0]   clip_top,
    input  logic signed [COORD_BITS-1:0]   clip_right,
    input  logic signed [COORD_BITS-1:0]   clip_bottom,
    input  logic                           pop,
    output tq_head_t                       head,
    output logic [6*COORD_BITS-1:0]        head_tri
);

    localparam int C = COORD_BITS;

    logic [6*C-1:0] tri_in;
    logic [3:0]     oc [3];
    logic [3:0]     oc_and;
    logic [3:0]     oc_or;
    logic [1:0]     cls_in;
    logic           push;

    logic [6*C-1:0] q_tri_reg [2];
    logic [1:0]     q_cls_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     cnt_reg, cnt_next;

    assign tri_in = {v2_y, v2_x, v1_y, v1_x, v0_y, v0_x};

    // Outcode of each vertex: left, right, top, bottom
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            oc[k][0] = $signed(tri_in[2*k*C +: C]) < clip_left;
            oc[k][1] = $signed(tri_in[2*k*C +: C]) > clip_right;
            oc[k][2] = $signed(tri_in[(2*k+1)*C +: C]) < clip_top;
            oc[k][3] = $signed(tri_in[(2*k+1)*C +: C]) > clip_bottom;
        end
    end

    // Fully outside one edge: nothing survives. Fully inside: kept as is.
    assign oc_and = oc[0] & oc[1] & oc[2];
    assign oc_or  = oc[0] | oc[1] | oc[2];

    always_comb
    begin
        priority if (oc_and != 4'd0)
        begin
            cls_in = CLS_REJECT;
        end
        else if (oc_or == 4'd0)
        begin
            cls_in = CLS_ACCEPT;
        end
        else
        begin
            cls_in = CLS_CLIP;
        end
    end

    // Two-entry item queue
    assign busy = cnt_reg == 2'd2;
    assign push = start && !busy;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_tri_reg[wr_ptr_reg] <= tri_in;
            q_cls_reg[wr_ptr_reg] <= cls_in;
        end
    end

    assign head.valid = cnt_reg != 2'd0;
    assign head.cls   = q_cls_reg[rd_ptr_reg];
    assign head_tri   = q_tri_reg[rd_ptr_reg];

    // The back end never pops an empty queue
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (cnt_reg != 2'd0))
        else $error("pop from empty triangle queue");

endmodule

// ===== design/tc_back.sv =====
// ============================================================================
// tc_back
// Clipping back end: four Sutherland-Hodgman passes between two vertex
// buffers, a shared multiplier and serial divider for crossings, and the
// vertex output stream.
// ============================================================================
module tc_back import tc_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  tq_head_t                       head,
    input  logic [6*COORD_BITS-1:0]        head_tri,
    output logic                           pop,
    input  logic signed [COORD_BITS-1:0]   clip_left,
    input  logic signed [COORD_BITS-1:0]   clip_top,
    input  logic signed [COORD_BITS-1:0]   clip_right,
    input  logic signed [COORD_BITS-1:0]   clip_bottom,
    output logic                           out_valid,
    output logic signed [COORD_BITS-1:0]   out_x,
    output logic signed [COORD_BITS-1:0]   out_y,
    output logic [2:0]                     vertex_number,
    output logic                           last_vertex
);

    localparam int C  = COORD_BITS;
    localparam int AW = $clog2(BUF_DEPTH);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_LOAD  = 4'd1;
    localparam logic [3:0] ST_PINIT = 4'd2;
    localparam logic [3:0] ST_PRV   = 4'd3;
    localparam logic [3:0] ST_RD    = 4'd4;
    localparam logic [3:0] ST_EVAL  = 4'd5;
    localparam logic [3:0] ST_MUL   = 4'd6;
    localparam logic [3:0] ST_DIVS  = 4'd7;
    localparam logic [3:0] ST_DIVW  = 4'd8;
    localparam logic [3:0] ST_WRCUR = 4'd9;
    localparam logic [3:0] ST_ADV   = 4'd10;
    localparam logic [3:0] ST_EMIT  = 4'd11;

    // Control registers
    logic [3:0]     state_reg, state_next;
    logic [1:0]     pass_reg, pass_next;
    logic [AW-1:0]  n_reg, n_next;
    logic [AW-1:0]  m_reg, m_next;
    logic [AW-1:0]  i_reg, i_next;
    logic [2:0]     k_reg, k_next;
    logic [1:0]     ld_reg, ld_next;
    logic           ov_reg, ov_next;

    // Payload registers
    logic [1:0]     cls_reg, cls_next;
    logic [6*C-1:0] tri_reg, tri_next;
    logic [2*C-1:0] prv_reg, prv_next;
    logic [2*C-1:0] cur_reg, cur_next;
    logic [C-1:0]   dmag_reg, dmag_next;
    logic [C-1:0]   nmag_reg, nmag_next;
    logic [C-1:0]   den_reg, den_next;
    logic           neg_reg, neg_next;
    logic           cin_reg, cin_next;
    logic [2*C-1:0] prod_reg, prod_next;
    logic [2:0]     num_reg, num_next;
    logic           last_reg, last_next;

    // Buffer ports
    logic           we_a, we_b;
    logic [AW-1:0]  waddr, raddr;
    logic [2*C-1:0] wdata;
    logic [2*C-1:0] rdata_a, rdata_b, src_data;

    // Divider
    logic           div_start, div_done;
    logic [C-1:0]   div_q;

    // Pass geometry
    logic                  axis_y;
    logic                  keep_ge;
    logic signed [C-1:0]   edge_val;
    logic signed [C-1:0]   cc, pc, co, po;
    logic                  cin, pin;
    logic [C:0]            dv, nv, dn;
    logic [C:0]            dabs, nabs, nden;
    logic [2*C-1:0]        cross_pt;
    logic [2:0]            emit_cnt;

    tc_ram #(.WIDTH(2*C), .DEPTH(BUF_DEPTH)) u_buf_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata_a)
    );

    tc_ram #(.WIDTH(2*C), .DEPTH(BUF_DEPTH)) u_buf_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata_b)
    );

    tc_div #(.W(C)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (den_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // Even passes read buffer A, odd passes read buffer B
    assign src_data = pass_reg[0] ? rdata_b : rdata_a;
    assign axis_y   = pass_reg[1];
    assign keep_ge  = !pass_reg[0];

    always_comb
    begin
        unique case (pass_reg)
            PASS_LEFT:   edge_val = clip_left;
            PASS_RIGHT:  edge_val = clip_right;
            PASS_TOP:    edge_val = clip_top;
            PASS_BOTTOM: edge_val = clip_bottom;
            default:     edge_val = clip_left;
        endcase
    end

    // Inside tests and crossing operands; words are {y, x}
    always_comb
    begin
        cc = axis_y ? $signed(src_data[2*C-1:C]) : $signed(src_data[C-1:0]);
        co = axis_y ? $signed(src_data[C-1:0])   : $signed(src_data[2*C-1:C]);
        pc = axis_y ? $signed(prv_reg[2*C-1:C])  : $signed(prv_reg[C-1:0]);
        po = axis_y ? $signed(prv_reg[C-1:0])    : $signed(prv_reg[2*C-1:C]);
        cin = keep_ge ? (cc >= edge_val) : (cc <= edge_val);
        pin = keep_ge ? (pc >= edge_val) : (pc <= edge_val);
        dv  = {co[C-1], co} - {po[C-1], po};
        nv  = {edge_val[C-1], edge_val} - {pc[C-1], pc};
        dn  = {cc[C-1], cc} - {pc[C-1], pc};
        dabs = dv[C] ? (~dv + 1'b1) : dv;
        nabs = nv[C] ? (~nv + 1'b1) : nv;
        nden = dn[C] ? (~dn + 1'b1) : dn;
    end

    // Crossing point from the quotient
    always_comb
    begin
        logic [C+1:0] base;
        logic [C+1:0] qx;
        logic [C+1:0] sum;
        base = axis_y ? {{2{prv_reg[C-1]}}, prv_reg[C-1:0]}
                      : {{2{prv_reg[2*C-1]}}, prv_reg[2*C-1:C]};
        qx   = {2'b00, div_q};
        sum  = neg_reg ? (base - qx) : (base + qx);
        cross_pt = axis_y ? {edge_val, sum[C-1:0]} : {sum[C-1:0], edge_val};
    end

    // Number of vertices to emit
    always_comb
    begin
        priority if (n_reg < AW'(MIN_OUT))
        begin
            emit_cnt = 3'd0;
        end
        else if (n_reg > AW'(MAX_OUT))
        begin
            emit_cnt = 3'(MAX_OUT);
        end
        else
        begin
            emit_cnt = n_reg[2:0];
        end
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        pass_next  = pass_reg;
        n_next     = n_reg;
        m_next     = m_reg;
        i_next     = i_reg;
        k_next     = k_reg;
        ld_next    = ld_reg;
        ov_next    = 1'b0;
        cls_next   = cls_reg;
        tri_next   = tri_reg;
        prv_next   = prv_reg;
        cur_next   = cur_reg;
        dmag_next  = dmag_reg;
        nmag_next  = nmag_reg;
        den_next   = den_reg;
        neg_next   = neg_reg;
        cin_next   = cin_reg;
        prod_next  = prod_reg;
        num_next   = num_reg;
        last_next  = last_reg;
        pop        = 1'b0;
        div_start  = 1'b0;
        we_a       = 1'b0;
        we_b       = 1'b0;
        waddr      = m_reg;
        wdata      = cur_reg;
        raddr      = i_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    pop      = 1'b1;
                    tri_next = head_tri;
                    cls_next = head.cls;
                    ld_next  = 2'd0;
                    if (head.cls != CLS_REJECT)
                    begin
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_LOAD:
            begin
                we_a    = 1'b1;
                waddr   = AW'(ld_reg);
                wdata   = tri_reg[ld_reg*2*C +: 2*C];
                ld_next = ld_reg + 1'b1;
                if (ld_reg == 2'd2)
                begin
                    n_next     = AW'(3);
                    pass_next  = PASS_LEFT;
                    k_next     = 3'd0;
                    state_next = (cls_reg == CLS_ACCEPT) ? ST_EMIT : ST_PINIT;
                end
            end
            ST_PINIT:
            begin
                // read the last vertex as predecessor of the first
                raddr = n_reg - 1'b1;
                if (n_reg == '0)
                begin
                    if (pass_reg == PASS_BOTTOM)
                    begin
                        k_next     = 3'd0;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        pass_next = pass_reg + 1'b1;
                    end
                end
                else
                begin
                    state_next = ST_PRV;
                end
            end
            ST_PRV:
            begin
                prv_next   = src_data;
                i_next     = '0;
                m_next     = '0;
                state_next = ST_RD;
            end
            ST_RD:
            begin
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                cur_next  = src_data;
                cin_next  = cin;
                dmag_next = dabs[C-1:0];
                nmag_next = nabs[C-1:0];
                den_next  = nden[C-1:0];
                neg_next  = dv[C] ^ nv[C] ^ dn[C];
                priority if (cin != pin)
                begin
                    state_next = ST_MUL;
                end
                else if (cin)
                begin
                    state_next = ST_WRCUR;
                end
                else
                begin
                    state_next = ST_ADV;
                end
            end
            ST_MUL:
            begin
                prod_next  = dmag_reg * nmag_reg;
                state_next = ST_DIVS;
            end
            ST_DIVS:
            begin
                div_start  = 1'b1;
                state_next = ST_DIVW;
            end
            ST_DIVW:
            begin
                if (div_done)
                begin
                    we_a       = pass_reg[0];
                    we_b       = !pass_reg[0];
                    wdata      = cross_pt;
                    m_next     = m_reg + 1'b1;
                    state_next = cin_reg ? ST_WRCUR : ST_ADV;
                end
            end
            ST_WRCUR:
            begin
                we_a       = pass_reg[0];
                we_b       = !pass_reg[0];
                m_next     = m_reg + 1'b1;
                state_next = ST_ADV;
            end
            ST_ADV:
            begin
                prv_next = cur_reg;
                if (i_reg == n_reg - 1'b1)
                begin
                    n_next = m_reg;
                    if (pass_reg == PASS_BOTTOM)
                    begin
                        k_next     = 3'd0;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        pass_next  = pass_reg + 1'b1;
                        state_next = ST_PINIT;
                    end
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = ST_RD;
                end
            end
            ST_EMIT:
            begin
                // final polygon sits in buffer A
                raddr = AW'(k_reg);
                if (emit_cnt == 3'd0)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    ov_next   = 1'b1;
                    num_next  = k_reg;
                    last_next = k_reg == emit_cnt - 1'b1;
                    if (k_reg == emit_cnt - 1'b1)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        k_next = k_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pass_reg  <= PASS_LEFT;
            n_reg     <= '0;
            m_reg     <= '0;
            i_reg     <= '0;
            k_reg     <= 3'd0;
            ld_reg    <= 2'd0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
            n_reg     <= n_next;
            m_reg     <= m_next;
            i_reg     <= i_next;
            k_reg     <= k_next;
            ld_reg    <= ld_next;
            ov_reg    <= ov_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        cls_reg  <= cls_next;
        tri_reg  <= tri_next;
        prv_reg  <= prv_next;
        cur_reg  <= cur_next;
        dmag_reg <= dmag_next;
        nmag_reg <= nmag_next;
        den_reg  <= den_next;
        neg_reg  <= neg_next;
        cin_reg  <= cin_next;
        prod_reg <= prod_next;
        num_reg  <= num_next;
        last_reg <= last_next;
    end

    assign out_valid     = ov_reg;
    assign out_x         = $signed(rdata_a[C-1:0]);
    assign out_y         = $signed(rdata_a[2*C-1:C]);
    assign vertex_number = num_reg;
    assign last_vertex   = last_reg;

    // A result follows a read issued while emitting
    a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg |-> $past(state_reg == ST_EMIT))
        else $error("result strobe outside emit");

    // Divider only finishes while a crossing waits for it
    a_div_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIVW))
        else $error("divider result with no crossing pending");

endmodule

// ===== design/triangle_rect_clipper.sv =====
// ============================================================================
// triangle_rect_clipper
// Clips one triangle against an axis-aligned window and streams the
// surviving polygon vertices.
// ============================================================================
// Usage:
//   Input: present v0..v2 and raise start; the triangle is taken at a
//   clock edge with start high and busy low. A two-entry queue sits
//   between the classifying front end and the clipping back end, so busy
//   rises only when two triangles are waiting.
//   Window: cfg_valid/cfg_ready write clip_left (index 0), clip_top (1),
//   clip_right (2), clip_bottom (3); cfg_ready is always high. Write only
//   while no triangle is in flight.
//   Output: each polygon vertex is shown for one cycle with out_valid,
//   vertex_number counting from 0 and last_vertex on the final one. The
//   receiver cannot stall. Polygons with fewer than three vertices give
//   no output.
//   Flow: a triangle fully outside one edge is dropped when it is taken;
//   one fully inside is taken, loaded and emitted. Otherwise take and load
//   are followed by the four passes; each reads its vertices, writes back
//   the kept ones and uses the serial divider for every edge crossing;
//   then comes an emit step per emitted vertex. Each strobe comes in the
//   cycle after its emit step.
//   Reset: window returns to 0..1023 on both axes (less if COORD_BITS is
//   below 11), queue and back end empty, no strobe.
// ============================================================================
module triangle_rect_clipper import tc_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic signed [COORD_BITS-1:0]   v0_x,
    input  logic signed [COORD_BITS-1:0]   v0_y,
    input  logic signed [COORD_BITS-1:0]   v1_x,
    input  logic signed [COORD_BITS-1:0]   v1_y,
    input  logic signed [COORD_BITS-1:0]   v2_x,
    input  logic signed [COORD_BITS-1:0]   v2_y,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]        cfg_index,
    input  logic [COORD_BITS-1:0]          cfg_data,
    output logic                           out_valid,
    output logic signed [COORD_BITS-1:0]   out_x,
    output logic signed [COORD_BITS-1:0]   out_y,
    output logic [2:0]                     vertex_number,
    output logic                           last_vertex
);

    localparam int C        = COORD_BITS;
    // far edge reset, clamped to the coordinate range
    localparam int EDGE_FAR = (C > 10) ? EDGE_FAR_RST : (2**(C-1) - 1);

    logic signed [C-1:0] left_reg, top_reg, right_reg, bottom_reg;
    tq_head_t            head;
    logic [6*C-1:0]      head_tri;
    logic                pop;

    assign cfg_ready = 1'b1;

    // Window registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg   <= '0;
            top_reg    <= '0;
            right_reg  <= C'(EDGE_FAR);
            bottom_reg <= C'(EDGE_FAR);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_LEFT:   left_reg   <= $signed(cfg_data);
                REG_TOP:    top_reg    <= $signed(cfg_data);
                REG_RIGHT:  right_reg  <= $signed(cfg_data);
                REG_BOTTOM: bottom_reg <= $signed(cfg_data);
                default:    left_reg   <= left_reg;
            endcase
        end
    end

    tc_front #(.COORD_BITS(C)) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .v0_x        (v0_x),
        .v0_y        (v0_y),
        .v1_x        (v1_x),
        .v1_y        (v1_y),
        .v2_x        (v2_x),
        .v2_y        (v2_y),
        .clip_left   (left_reg),
        .clip_top    (top_reg),
        .clip_right  (right_reg),
        .clip_bottom (bottom_reg),
        .pop         (pop),
        .head        (head),
        .head_tri    (head_tri)
    );

    tc_back #(.COORD_BITS(C)) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .head_tri      (head_tri),
        .pop           (pop),
        .clip_left     (left_reg),
        .clip_top      (top_reg),
        .clip_right    (right_reg),
        .clip_bottom   (bottom_reg),
        .out_valid     (out_valid),
        .out_x         (out_x),
        .out_y         (out_y),
        .vertex_number (vertex_number),
        .last_vertex   (last_vertex)
    );

endmodule

// ===== tb/tri_clip_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tri_clip_checker
// Watches the triangle, window and vertex channels of the clipper, works out
// the clipped polygon of every accepted triangle and compares each emitted
// vertex with the oldest one still expected.
// ----------------------------------------------------------------------------
module tri_clip_checker import tc_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic                           busy,
    input  logic signed [COORD_BITS-1:0]   v0_x,
    input  logic signed [COORD_BITS-1:0]   v0_y,
    input  logic signed [COORD_BITS-1:0]   v1_x,
    input  logic signed [COORD_BITS-1:0]   v1_y,
    input  logic signed [COORD_BITS-1:0]   v2_x,
    input  logic signed [COORD_BITS-1:0]   v2_y,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]        cfg_index,
    input  logic [COORD_BITS-1:0]          cfg_data,
    input  logic                           out_valid,
    input  logic signed [COORD_BITS-1:0]   out_x,
    input  logic signed [COORD_BITS-1:0]   out_y,
    input  logic [2:0]                     vertex_number,
    input  logic                           last_vertex,
    output int                             fail_count,
    output int                             pending_vertices,
    output int                             triangles_seen,
    output int                             empty_polygons,
    output int                             vertices_seen
);

    typedef struct {
        longint x;
        longint y;
    } point_t;

    typedef struct {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic [2:0]                   num;
        logic                         last;
    } vertex_t;

    vertex_t expected_vertices[$];

    // Window copy, tracked from the register write channel
    longint win_left, win_top, win_right, win_bottom;

    // Working polygon; each pass rewrites it in place
    point_t poly_cur[BUF_DEPTH];
    point_t poly_nxt[BUF_DEPTH];
    int     poly_len;

    // Crossing: base + d * num / den, truncated toward zero
    function automatic longint cross_coord(longint base, longint d, longint num,
                                           longint den);
        if (den == 0)
            return base;
        return base + (d * num) / den;
    endfunction

    // One clip pass against a single window edge
    function void clip_against(bit on_y, bit keep_ge, longint edge_pos);
        int     m;
        point_t cur;
        point_t prv;
        point_t p;
        longint cc;
        longint pc;
        bit     cin;
        bit     pin;
        m = 0;
        for (int i = 0; i < poly_len; i++)
        begin
            cur = poly_cur[i];
            prv = poly_cur[(i + poly_len - 1) % poly_len];
            cc  = on_y ? cur.y : cur.x;
            pc  = on_y ? prv.y : prv.x;
            cin = keep_ge ? (cc >= edge_pos) : (cc <= edge_pos);
            pin = keep_ge ? (pc >= edge_pos) : (pc <= edge_pos);
            if (cin != pin && m < BUF_DEPTH)
            begin
                if (on_y)
                begin
                    p.y = edge_pos;
                    p.x = cross_coord(prv.x, cur.x - prv.x, edge_pos - pc, cc - pc);
                end
                else
                begin
                    p.x = edge_pos;
                    p.y = cross_coord(prv.y, cur.y - prv.y, edge_pos - pc, cc - pc);
                end
                poly_nxt[m] = p;
                m++;
            end
            if (cin && m < BUF_DEPTH)
            begin
                poly_nxt[m] = cur;
                m++;
            end
        end
        for (int i = 0; i < m; i++)
            poly_cur[i] = poly_nxt[i];
        poly_len = m;
    endfunction

    // Clip one triangle and queue the vertices it should produce
    function void predict_polygon();
        int      cnt;
        vertex_t v;
        poly_cur[0].x = v0_x;  poly_cur[0].y = v0_y;
        poly_cur[1].x = v1_x;  poly_cur[1].y = v1_y;
        poly_cur[2].x = v2_x;  poly_cur[2].y = v2_y;
        poly_len = 3;
        clip_against(1'b0, 1'b1, win_left);
        clip_against(1'b0, 1'b0, win_right);
        clip_against(1'b1, 1'b1, win_top);
        clip_against(1'b1, 1'b0, win_bottom);
        if (poly_len < MIN_OUT)
        begin
            empty_polygons++;
            return;
        end
        cnt = (poly_len > MAX_OUT) ? MAX_OUT : poly_len;
        for (int k = 0; k < cnt; k++)
        begin
            v.x    = poly_cur[k].x[COORD_BITS-1:0];
            v.y    = poly_cur[k].y[COORD_BITS-1:0];
            v.num  = k[2:0];
            v.last = (k == cnt - 1);
            expected_vertices.insert(expected_vertices.size(), v);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        vertex_t e;
        if (!rst_n)
        begin
            win_left   = 0;
            win_top    = 0;
            win_right  = EDGE_FAR_RST;
            win_bottom = EDGE_FAR_RST;
            expected_vertices.delete();
            fail_count       = 0;
            triangles_seen   = 0;
            empty_polygons   = 0;
            vertices_seen    = 0;
            pending_vertices = 0;
        end
        else
        begin
            // Emitted vertex against the oldest expectation
            if (out_valid)
            begin
                vertices_seen++;
                if (expected_vertices.size() == 0)
                begin
                    $display("%0t: unexpected vertex (%0d,%0d) #%0d last %0b", $time,
                             out_x, out_y, vertex_number, last_vertex);
                    fail_count++;
                end
                else
                begin
                    e = expected_vertices.pop_front();
                    if (out_x !== e.x)
                    begin
                        $display("%0t: out_x expected %0d actual %0d", $time, e.x, out_x);
                        fail_count++;
                    end
                    if (out_y !== e.y)
                    begin
                        $display("%0t: out_y expected %0d actual %0d", $time, e.y, out_y);
                        fail_count++;
                    end
                    if (vertex_number !== e.num)
                    begin
                        $display("%0t: vertex_number expected %0d actual %0d", $time,
                                 e.num, vertex_number);
                        fail_count++;
                    end
                    if (last_vertex !== e.last)
                    begin
                        $display("%0t: last_vertex expected %0b actual %0b", $time,
                                 e.last, last_vertex);
                        fail_count++;
                    end
                end
            end
            // Window register writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_LEFT:   win_left   = $signed(cfg_data);
                    REG_TOP:    win_top    = $signed(cfg_data);
                    REG_RIGHT:  win_right  = $signed(cfg_data);
                    REG_BOTTOM: win_bottom = $signed(cfg_data);
                    default: ;
                endcase
            end
            // Accepted triangle
            if (start && !busy)
            begin
                triangles_seen++;
                predict_polygon();
            end
            pending_vertices = expected_vertices.size();
        end
    end

endmodule

// ===== tb/triangle_rect_clipper_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// triangle_rect_clipper_tb
// Drives triangles and window settings into the clipper with random gaps;
// a checker beside the block predicts every clipped polygon and compares.
// ----------------------------------------------------------------------------
module triangle_rect_clipper_tb;
    import tc_pkg::*;

    localparam int CB             = 16;
    localparam int SETTLE_CYCLES  = 800;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_PER_WIN = 78;
    localparam int CMIN           = -32768;
    localparam int CMAX           = 32767;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic signed [CB-1:0]  v0_x = '0, v0_y = '0, v1_x = '0, v1_y = '0;
    logic signed [CB-1:0]  v2_x = '0, v2_y = '0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index = REG_LEFT;
    logic [CB-1:0]         cfg_data = '0;
    logic                  out_valid;
    logic signed [CB-1:0]  out_x, out_y;
    logic [2:0]            vertex_number;
    logic                  last_vertex;

    int fail_count, pending_vertices, triangles_seen, empty_polygons, vertices_seen;
    int idle_cycles = 0;
    int win_lo_x, win_hi_x, win_lo_y, win_hi_y;

    always #5 clk = ~clk;

    triangle_rect_clipper #(.COORD_BITS(CB)) u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .v0_x(v0_x), .v0_y(v0_y), .v1_x(v1_x), .v1_y(v1_y), .v2_x(v2_x), .v2_y(v2_y),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .out_valid(out_valid), .out_x(out_x), .out_y(out_y),
        .vertex_number(vertex_number), .last_vertex(last_vertex)
    );

    tri_clip_checker #(.COORD_BITS(CB)) u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .v0_x(v0_x), .v0_y(v0_y), .v1_x(v1_x), .v1_y(v1_y), .v2_x(v2_x), .v2_y(v2_y),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .out_valid(out_valid), .out_x(out_x), .out_y(out_y),
        .vertex_number(vertex_number), .last_vertex(last_vertex),
        .fail_count(fail_count), .pending_vertices(pending_vertices),
        .triangles_seen(triangles_seen), .empty_polygons(empty_polygons),
        .vertices_seen(vertices_seen)
    );

    // Watchdog: cycles in a row with no item moving on any channel
    always @(posedge clk)
    begin
        if ((start && !busy) || out_valid || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Present one triangle after a random gap; returns at its accepting edge
    task automatic send_triangle(int ax, int ay, int bx, int by, int cx, int cy);
        int gap;
        gap = $urandom_range(0, 7);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        v0_x <= ax[CB-1:0];  v0_y <= ay[CB-1:0];
        v1_x <= bx[CB-1:0];  v1_y <= by[CB-1:0];
        v2_x <= cx[CB-1:0];  v2_y <= cy[CB-1:0];
        do
            @(negedge clk);
        while (busy);
        @(posedge clk);
    endtask

    // Stop sending and let every expected vertex and stray triangle drain
    task automatic drain();
        start <= 1'b0;
        do
            @(negedge clk);
        while (pending_vertices != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register write after a random gap
    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, int value);
        int gap;
        gap = $urandom_range(0, 7);
        if (gap > 0)
        begin
            cfg_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CB-1:0];
        do
            @(negedge clk);
        while (!cfg_ready);
        @(posedge clk);
    endtask

    // Set the whole window; called only with the block drained
    task automatic set_window(int l, int t, int r, int b);
        write_reg(REG_LEFT, l);
        write_reg(REG_TOP, t);
        write_reg(REG_RIGHT, r);
        write_reg(REG_BOTTOM, b);
        cfg_valid <= 1'b0;
        win_lo_x = l;  win_hi_x = r;
        win_lo_y = t;  win_hi_y = b;
    endtask

    // Coordinate around the window span; sometimes any 16-bit value
    function automatic int pick_coord(int lo, int hi);
        int a, b, span, v;
        if ($urandom_range(0, 7) == 0)
            return int'($urandom_range(0, 65535)) - 32768;
        a = (lo < hi) ? lo : hi;
        b = (lo < hi) ? hi : lo;
        span = (b - a) / 2 + 32;
        v = a - span + int'($urandom_range(0, b - a + 2 * span));
        if (v < CMIN) v = CMIN;
        if (v > CMAX) v = CMAX;
        return v;
    endfunction

    task automatic random_triangles(int count);
        for (int i = 0; i < count; i++)
            send_triangle(pick_coord(win_lo_x, win_hi_x), pick_coord(win_lo_y, win_hi_y),
                          pick_coord(win_lo_x, win_hi_x), pick_coord(win_lo_y, win_hi_y),
                          pick_coord(win_lo_x, win_hi_x), pick_coord(win_lo_y, win_hi_y));
    endtask

    initial
    begin
        int l, t;
        win_lo_x = 0;  win_hi_x = EDGE_FAR_RST;
        win_lo_y = 0;  win_hi_y = EDGE_FAR_RST;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed triangles against the reset window 0..1023
        send_triangle(100, 100, 900, 200, 500, 800);          // fully inside
        send_triangle(-500, 10, -100, 900, -300, 400);        // all left
        send_triangle(1100, 10, 2000, 900, 1500, 400);        // all right
        send_triangle(10, -900, 900, -100, 500, -50);         // all above
        send_triangle(10, 1100, 900, 2000, 500, 3000);        // all below
        send_triangle(-200, 500, 300, 100, 300, 900);         // crosses left edge
        send_triangle(800, 100, 1500, 500, 800, 900);         // crosses right edge
        send_triangle(-3000, -3000, 6000, -3000, -3000, 6000); // covers window
        send_triangle(-300, 500, 500, -300, 1400, 1300);      // cuts several corners
        send_triangle(512, 512, 512, 512, 512, 512);          // single point
        send_triangle(0, 0, 1023, 0, 1023, 1023);             // vertices on edges
        send_triangle(0, 0, 400, 400, 800, 800);              // collinear
        send_triangle(CMIN, CMIN, CMAX, CMIN, CMIN, CMAX);    // extreme corners
        send_triangle(CMAX, CMAX, CMIN, CMAX, CMAX, CMIN);
        send_triangle(CMIN, CMAX, CMAX, CMIN, CMIN, CMIN);
        send_triangle(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX);
        send_triangle(-1, -1, 1024, -1, 500, 1024);           // just outside edges
        // Hold off until the polygon stream is empty
        drain();

        random_triangles(RANDOM_PER_WIN);
        drain();

        // Widest window
        set_window(CMIN, CMIN, CMAX, CMAX);
        send_triangle(CMIN, CMIN, CMAX, CMIN, CMIN, CMAX);
        random_triangles(RANDOM_PER_WIN);
        drain();

        // Narrowest window at the positive extreme
        set_window(CMAX, CMAX, CMAX, CMAX);
        send_triangle(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX);
        random_triangles(RANDOM_PER_WIN / 2);
        drain();

        // Tiny window
        set_window(-3, 5, 4, 9);
        random_triangles(RANDOM_PER_WIN);
        drain();

        // Inverted window
        set_window(500, 400, 100, -200);
        random_triangles(RANDOM_PER_WIN / 2);
        drain();

        // Random windows of moderate size
        for (int w = 0; w < 2; w++)
        begin
            l = int'($urandom_range(0, 8000)) - 4000;
            t = int'($urandom_range(0, 8000)) - 4000;
            set_window(l, t, l + int'($urandom_range(1, 3000)),
                       t + int'($urandom_range(1, 3000)));
            random_triangles(RANDOM_PER_WIN);
            drain();
        end

        $display("Covered %0d triangles over 7 windows: %0d vertices emitted, %0d empty polygons",
                 triangles_seen, vertices_seen, empty_polygons);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
design/tc_pkg.sv
design/tc_ram.sv
design/tc_div.sv
design/tc_front.sv
design/tc_back.sv
design/triangle_rect_clipper.sv
tb/tri_clip_checker.sv
tb/triangle_rect_clipper_tb.sv
